/* hw/rtl/dqe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_REAR,
    ACT_PUSH_FRONT,
    ACT_POP_FRONT,
    ACT_ROTATE
  } cell_act_e;

  typedef struct packed {
    cell_act_e               act;
    logic [CNT_W-1:0]        fill;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/dqe_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module dqe_cell (
  input  wire logic                             clk_i,
  input  wire dqe_pkg::cell_cmd_t               cmd_i,
  input  wire logic [dqe_pkg::IDX_W-1:0]        idx_i,
  input  wire logic signed [dqe_pkg::DATA_W-1:0] left_i,
  input  wire logic signed [dqe_pkg::DATA_W-1:0] right_i,
  input  wire logic signed [dqe_pkg::DATA_W-1:0] wrap_i,
  output logic signed [dqe_pkg::DATA_W-1:0]      data_o
);

  logic signed [dqe_pkg::DATA_W-1:0] data_q, data_d;
  logic [dqe_pkg::CNT_W-1:0]         pos;

  assign pos = dqe_pkg::CNT_W'(idx_i);

  always_comb begin
    data_d = data_q;
    case (cmd_i.act)
      dqe_pkg::ACT_PUSH_REAR: begin
        if (pos == cmd_i.fill) data_d = cmd_i.value;
      end
      dqe_pkg::ACT_PUSH_FRONT: begin
        data_d = (idx_i == '0) ? cmd_i.value : left_i;
      end
      dqe_pkg::ACT_POP_FRONT: begin
        data_d = right_i;
      end
      dqe_pkg::ACT_ROTATE: begin
        // front word goes round to the last occupied cell
        data_d = (pos + 1'b1 == cmd_i.fill) ? wrap_i : right_i;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* hw/rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded deque of signed 32-bit words held in a row of cells, front in cell 0.
// Input channel: op_i/value_i with in_valid_i/in_ready_o. Ops push rear, push
// front, pop rear, pop front, list; other codes are taken and give no beat.
// Output channel: data_o/status_o/count_o/last_o with out_valid_o/out_ready_i.
// Pushes and pops give one beat, in the cycle after acceptance. Unless the
// output stalls, a new item can be taken every cycle: the cells shift or
// load in the accepting cycle. A list gives one beat per element held (one
// beat of status empty when the deque is empty); the row rotates by one cell
// per beat, and the input waits until the last beat of the list is issued.
// Push into a full deque and pop or list of an empty one give a status beat
// and leave the contents alone.
// Reset empties the deque and drops any pending output beat; cell contents
// are not cleared. If the receiver stalls, the output register holds its
// beat and the block takes no further input until the beat is taken.
module double_ended_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [dqe_pkg::OP_W-1:0]          op_i,
  input  wire logic signed [dqe_pkg::DATA_W-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [dqe_pkg::DATA_W-1:0]      data_o,
  output logic [dqe_pkg::ST_W-1:0]               status_o,
  output logic [dqe_pkg::CNT_W-1:0]              count_o,
  output logic                                   last_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic state_q, state_d;
  logic [dqe_pkg::CNT_W-1:0] fill_q, fill_d;
  logic [dqe_pkg::CNT_W-1:0] lcnt_q, lcnt_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [dqe_pkg::DATA_W-1:0] out_data_q, out_data_d;
  logic [dqe_pkg::ST_W-1:0]          out_status_q, out_status_d;
  logic [dqe_pkg::CNT_W-1:0]         out_count_q, out_count_d;
  logic                              out_last_q, out_last_d;

  dqe_pkg::cell_cmd_t cmd;
  logic signed [dqe_pkg::DATA_W-1:0] cell_data [dqe_pkg::DEPTH];
  logic [dqe_pkg::CNT_W-1:0]         rear_pos;
  logic signed [dqe_pkg::DATA_W-1:0] rear_data;
  logic accept, out_free, is_full, is_empty, list_last;

  for (genvar g = 0; g < dqe_pkg::DEPTH; g++) begin : g_cell
    logic signed [dqe_pkg::DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == dqe_pkg::DEPTH - 1) begin : g_end
      assign right = cell_data[0];
    end else begin : g_body
      assign right = cell_data[g+1];
    end
    dqe_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (dqe_pkg::IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .wrap_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign rear_pos  = fill_q - 1'b1;
  assign rear_data = cell_data[rear_pos[dqe_pkg::IDX_W-1:0]];
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept    = in_valid_i && in_ready_o;
  assign is_full   = (fill_q == dqe_pkg::CNT_W'(dqe_pkg::DEPTH));
  assign is_empty  = (fill_q == '0);
  assign list_last = (lcnt_q + 1'b1 == fill_q);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    lcnt_d       = lcnt_q;
    cmd.act      = dqe_pkg::ACT_NONE;
    cmd.fill     = fill_q;
    cmd.value    = value_i;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;

    if (accept) begin
      case (op_i)
        dqe_pkg::OP_PUSH_REAR, dqe_pkg::OP_PUSH_FRONT: begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_last_d  = 1'b1;
          if (is_full) begin
            out_status_d = dqe_pkg::ST_FULL;
            out_count_d  = fill_q;
          end else begin
            cmd.act      = (op_i == dqe_pkg::OP_PUSH_REAR) ? dqe_pkg::ACT_PUSH_REAR
                                                           : dqe_pkg::ACT_PUSH_FRONT;
            fill_d       = fill_q + 1'b1;
            out_status_d = dqe_pkg::ST_OK;
            out_count_d  = fill_q + 1'b1;
          end
        end
        dqe_pkg::OP_POP_REAR, dqe_pkg::OP_POP_FRONT: begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (is_empty) begin
            out_data_d   = '0;
            out_status_d = dqe_pkg::ST_EMPTY;
            out_count_d  = '0;
          end else begin
            if (op_i == dqe_pkg::OP_POP_FRONT) begin
              cmd.act    = dqe_pkg::ACT_POP_FRONT;
              out_data_d = cell_data[0];
            end else begin
              out_data_d = rear_data;
            end
            fill_d       = rear_pos;
            out_status_d = dqe_pkg::ST_OK;
            out_count_d  = rear_pos;
          end
        end
        dqe_pkg::OP_LIST: begin
          out_valid_d = 1'b1;
          out_count_d = fill_q;
          if (is_empty) begin
            out_data_d   = '0;
            out_status_d = dqe_pkg::ST_EMPTY;
            out_last_d   = 1'b1;
          end else begin
            cmd.act      = dqe_pkg::ACT_ROTATE;
            out_data_d   = cell_data[0];
            out_status_d = dqe_pkg::ST_OK;
            out_last_d   = (fill_q == dqe_pkg::CNT_W'(1));
            lcnt_d       = dqe_pkg::CNT_W'(1);
            if (fill_q != dqe_pkg::CNT_W'(1)) state_d = S_LIST;
          end
        end
        default: begin
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
    end else if (state_q == S_LIST && out_free) begin
      // one element per beat; after fill_q rotations the row is back in order
      cmd.act      = dqe_pkg::ACT_ROTATE;
      out_valid_d  = 1'b1;
      out_data_d   = cell_data[0];
      out_status_d = dqe_pkg::ST_OK;
      out_count_d  = fill_q;
      out_last_d   = list_last;
      lcnt_d       = lcnt_q + 1'b1;
      if (list_last) state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      lcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      lcnt_q      <= lcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;
  assign last_o      = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= dqe_pkg::CNT_W'(dqe_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_full_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full && (op_i == dqe_pkg::OP_PUSH_REAR ||
     op_i == dqe_pkg::OP_PUSH_FRONT)) |=> $stable(fill_q))
    else $error("refused push changed the fill count");

  a_list_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST) |-> (lcnt_q < fill_q && lcnt_q != '0))
    else $error("list beat counter out of range");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == dqe_pkg::ST_EMPTY) |->
    (out_count_q == '0 && out_last_q))
    else $error("empty status beat malformed");

endmodule

`default_nettype wire

/* dv/tb_double_ended_queue.sv */
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import dqe_pkg::*;

  localparam int N_RANDOM   = 423;
  localparam int N_PLAN     = 23;
  localparam int MAX_WAIT   = 18;
  localparam int TAIL_CYC   = 40;
  localparam int MAX_PRINTS = 40;

  // op codes the block takes and drops without a beat
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam logic signed [DATA_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] WORD_ONES = 32'shffff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } beat_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [4:0]               reps;
    logic                     typed;
    logic signed [DATA_W-1:0] t_data;
    logic [ST_W-1:0]          t_status;
    logic [CNT_W-1:0]         t_count;
  } plan_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          op_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] data_o;
  logic [ST_W-1:0]          status_o;
  logic [CNT_W-1:0]         count_o;
  logic                     last_o;

  double_ended_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow deque
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int unsigned              shadow_front;
  int unsigned              shadow_held;

  beat_t     beats_due[$];
  plan_row_t plan [N_PLAN];

  int n_errors, n_items, n_beats, n_lists, n_full, n_empty, n_spare;
  bit in_calm, out_calm;
  int in_draws, out_draws;

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Applies one op to the shadow deque and queues the beats it should give.
  task automatic apply_to_shadow(input logic [OP_W-1:0] op,
                                 input logic signed [DATA_W-1:0] val);
    beat_t       b;
    int unsigned slot;
    b = '{data: '0, status: ST_OK, count: '0, last: 1'b1};
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (shadow_held == DEPTH) begin
          b.status = ST_FULL;
          n_full++;
        end else begin
          if (op == OP_PUSH_REAR) begin
            slot = (shadow_front + shadow_held) % DEPTH;
          end else begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            slot = shadow_front;
          end
          shadow_words[slot] = val;
          shadow_held++;
        end
        b.count = CNT_W'(shadow_held);
        beats_due.push_back(b);
      end
      OP_POP_REAR, OP_POP_FRONT: begin
        if (shadow_held == 0) begin
          b.status = ST_EMPTY;
          n_empty++;
        end else begin
          if (op == OP_POP_REAR) begin
            b.data = shadow_words[(shadow_front + shadow_held - 1) % DEPTH];
          end else begin
            b.data = shadow_words[shadow_front];
            shadow_front = (shadow_front + 1) % DEPTH;
          end
          shadow_held--;
        end
        b.count = CNT_W'(shadow_held);
        beats_due.push_back(b);
      end
      OP_LIST: begin
        n_lists++;
        if (shadow_held == 0) begin
          b.status = ST_EMPTY;
          n_empty++;
          beats_due.push_back(b);
        end else begin
          for (int k = 0; k < shadow_held; k++) begin
            b.data  = shadow_words[(shadow_front + k) % DEPTH];
            b.count = CNT_W'(shadow_held);
            b.last  = (k + 1 == shadow_held);
            beats_due.push_back(b);
          end
        end
      end
      default: n_spare++;
    endcase
  endtask

  // Presents one beat after a random gap and waits for it to be taken.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [DATA_W-1:0] val,
                           input bit typed, input beat_t typed_beat);
    int gap;
    if (in_draws % 32 == 0) in_calm = ($urandom_range(0, 2) == 0);
    in_draws++;
    gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_items++;
    apply_to_shadow(op, val);
    if (typed && beats_due.size() != 0) beats_due[$] = typed_beat;
  endtask

  // receiver: random stall before each beat
  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      if (out_draws % 32 == 0) out_calm = ($urandom_range(0, 2) == 0);
      out_draws++;
      stall = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : monitor
    beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_beats++;
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%0d status=%0d count=%0d last=%0b",
                                  data_o, status_o, count_o, last_o));
      end else begin
        want = beats_due.pop_front();
        if (data_o !== want.data)
          report_mismatch($sformatf("data got %0d want %0d", data_o, want.data));
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (count_o !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", count_o, want.count));
        if (last_o !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", last_o, want.last));
      end
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("timeout: %0d beats still due after %0d items", beats_due.size(), n_items);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    beat_t                    tb;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] val;
    int                       push_pct;
    int                       r;

    shadow_front = 0;
    shadow_held  = 0;

    //         op             value       reps typ t_data      t_status  t_count
    plan[0]  = '{OP_POP_REAR,   32'sd0,     5'd1, 1'b1, 32'sd0,    ST_EMPTY, 5'd0};
    plan[1]  = '{OP_POP_FRONT,  32'sd0,     5'd1, 1'b1, 32'sd0,    ST_EMPTY, 5'd0};
    plan[2]  = '{OP_LIST,       32'sd0,     5'd1, 1'b1, 32'sd0,    ST_EMPTY, 5'd0};
    plan[3]  = '{OP_PUSH_REAR,  WORD_MAX,   5'd1, 1'b1, 32'sd0,    ST_OK,    5'd1};
    plan[4]  = '{OP_PUSH_FRONT, WORD_MIN,   5'd1, 1'b1, 32'sd0,    ST_OK,    5'd2};
    plan[5]  = '{OP_LIST,       32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[6]  = '{OP_POP_REAR,   WORD_ONES,  5'd1, 1'b1, WORD_MAX,  ST_OK,    5'd1};
    plan[7]  = '{OP_POP_FRONT,  WORD_ONES,  5'd1, 1'b1, WORD_MIN,  ST_OK,    5'd0};
    plan[8]  = '{OP_SPARE_LO,   WORD_MAX,   5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[9]  = '{OP_SPARE_HI,   WORD_MIN,   5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[10] = '{OP_POP_FRONT,  32'sd0,     5'd1, 1'b1, 32'sd0,    ST_EMPTY, 5'd0};
    plan[11] = '{OP_PUSH_FRONT, 32'sd1,     5'd1, 1'b1, 32'sd0,    ST_OK,    5'd1};
    plan[12] = '{OP_POP_REAR,   32'sd0,     5'd1, 1'b1, 32'sd1,    ST_OK,    5'd0};
    // fill to the brim from both ends
    plan[13] = '{OP_PUSH_REAR,  WORD_ONES,  5'd8, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[14] = '{OP_PUSH_FRONT, 32'sh5555_aaaa, 5'd8, 1'b0, 32'sd0, ST_OK,   5'd0};
    plan[15] = '{OP_PUSH_REAR,  WORD_MAX,   5'd1, 1'b1, 32'sd0,    ST_FULL,  5'd16};
    plan[16] = '{OP_PUSH_FRONT, WORD_MIN,   5'd1, 1'b1, 32'sd0,    ST_FULL,  5'd16};
    plan[17] = '{OP_SPARE_MID,  32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[18] = '{OP_LIST,       32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[19] = '{OP_POP_FRONT,  32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[20] = '{OP_PUSH_REAR,  32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[21] = '{OP_POP_REAR,   32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};
    plan[22] = '{OP_LIST,       32'sd0,     5'd1, 1'b0, 32'sd0,    ST_OK,    5'd0};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_PLAN; i++) begin
      tb = '{data: plan[i].t_data, status: plan[i].t_status,
             count: plan[i].t_count, last: 1'b1};
      for (int k = 0; k < plan[i].reps; k++)
        send_item(plan[i].op, plan[i].value ^ DATA_W'(k), plan[i].typed, tb);
    end

    // random part: push bias changes in phases so the fill roams empty to full
    push_pct = 50;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end else if (r < 10) begin
        op = OP_LIST;
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
      end
      case ($urandom_range(0, 15))
        0:       val = WORD_MIN;
        1:       val = WORD_MAX;
        2:       val = WORD_ONES;
        3:       val = '0;
        default: val = $urandom();
      endcase
      send_item(op, val, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("run: %0d items (%0d lists, %0d ignored codes), %0d beats checked",
             n_items, n_lists, n_spare, n_beats);
    $display("refusals: %0d full pushes, %0d empty pops or lists; %0d mismatches",
             n_full, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dqe_pkg.sv
hw/rtl/dqe_cell.sv
hw/rtl/double_ended_queue.sv
dv/tb_double_ended_queue.sv
